@@ hw/rtl/hdlcft_pkg.sv @@
// hdlcft_pkg: shared types and constants for the HDLC frame bit transmitter.
// Used by hdlcft_crc, hdlcft_seq and hdlc_frame_bit_transmitter. No dependencies.
package hdlcft_pkg;

    localparam int unsigned CRC_W      = 16;
    localparam int unsigned PRE_W      = 7;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 7;
    localparam int unsigned CNT_W      = 7;
    localparam int unsigned RUN_W      = 3;

    localparam logic [CRC_W-1:0] CRC_INIT     = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY     = 16'h8408;
    localparam logic [7:0]       FLAG_BITS    = 8'h7E;
    localparam logic [RUN_W-1:0] STUFF_RUN    = 3'd5;
    localparam logic [PRE_W-1:0] PREAMBLE_MAX = 7'd64;
    localparam logic [PRE_W-1:0] PREAMBLE_RST = 7'd20;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PREAMBLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NRZI     = 2'd1;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_FLAG  = 2'd1,
        OP_DATA  = 2'd2,
        OP_END   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_PRE,
        SEQ_SHIFT
    } seq_state_t;

    // control toward the bit-serial CRC
    typedef struct packed {
        logic init;
        logic shift;
        logic din;
    } crc_ctl_t;

    // one line bit leaving the sequencer
    typedef struct packed {
        logic valid;
        logic lbit;
        logic last;
        logic lvl_rst;
    } emit_t;

endpackage

@@ hw/rtl/hdlcft_crc.sv @@
// hdlcft_crc: bit-serial reflected CRC-16 (poly 0x8408), one data bit per cycle while ctl.shift is high.
// Depends on hdlcft_pkg.
module hdlcft_crc (
    input  logic                           clk,
    input  logic                           rst_n,
    input  hdlcft_pkg::crc_ctl_t           ctl,
    output logic [hdlcft_pkg::CRC_W-1:0]   crc
);

    logic [hdlcft_pkg::CRC_W-1:0] crc_reg;
    logic [hdlcft_pkg::CRC_W-1:0] crc_next;
    logic                         mix;

    assign mix = ctl.din ^ crc_reg[0];

    always_comb
    begin
        crc_next = crc_reg;
        if (ctl.init)
        begin
            crc_next = hdlcft_pkg::CRC_INIT;
        end
        else if (ctl.shift)
        begin
            crc_next = (crc_reg >> 1) ^ (mix ? hdlcft_pkg::CRC_POLY : '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= hdlcft_pkg::CRC_INIT;
        end
        else
        begin
            crc_reg <= crc_next;
        end
    end

    assign crc = crc_reg;

    a_crc_init: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.init |=> crc_reg == hdlcft_pkg::CRC_INIT)
        else $error("crc not reloaded on start");

endmodule

@@ hw/rtl/hdlcft_seq.sv @@
// hdlcft_seq: opcode sequencer with the shared shift register, stuffing counter
// and preamble counter. Depends on hdlcft_pkg.
module hdlcft_seq (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          opcode,
    input  logic [7:0]                          data_byte,
    input  logic [hdlcft_pkg::PRE_W-1:0]        preamble,
    input  logic [hdlcft_pkg::CRC_W-1:0]        crc,
    input  logic                                adv,
    output hdlcft_pkg::crc_ctl_t                crc_ctl,
    output hdlcft_pkg::emit_t                   emit
);

    hdlcft_pkg::seq_state_t state_reg, state_next;

    logic [hdlcft_pkg::CRC_W-1:0] sh_reg, sh_next;
    logic [hdlcft_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [hdlcft_pkg::RUN_W-1:0] ones_reg, ones_next;
    logic                         stuff_pend_reg, stuff_pend_next;
    logic                         stuff_en_reg, stuff_en_next;
    logic                         is_data_reg, is_data_next;
    logic                         flag_pend_reg, flag_pend_next;

    hdlcft_pkg::op_t              op;
    logic                         in_fire;
    logic                         step;
    logic                         bit_cur;
    logic                         stuff_now;
    logic                         shift_done;
    logic [hdlcft_pkg::CNT_W-1:0] pre_cnt;

    assign op       = hdlcft_pkg::op_t'(opcode);
    assign in_ready = (state_reg == hdlcft_pkg::SEQ_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign step     = adv && (state_reg != hdlcft_pkg::SEQ_IDLE);
    assign pre_cnt  = (preamble > hdlcft_pkg::PREAMBLE_MAX) ? hdlcft_pkg::PREAMBLE_MAX
                                                          : preamble;

    assign bit_cur    = stuff_pend_reg ? 1'b0 : sh_reg[0];
    // fifth one in a row: a zero goes out next
    assign stuff_now  = !stuff_pend_reg && stuff_en_reg && sh_reg[0]
                        && (ones_reg == hdlcft_pkg::STUFF_RUN - 3'd1);
    assign shift_done = stuff_pend_reg ? (cnt_reg == '0)
                                       : ((cnt_reg == 7'd1) && !stuff_now);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hdlcft_pkg::SEQ_IDLE:
            begin
                if (in_fire)
                begin
                    if (op == hdlcft_pkg::OP_START)
                    begin
                        state_next = (pre_cnt == '0) ? hdlcft_pkg::SEQ_IDLE
                                                     : hdlcft_pkg::SEQ_PRE;
                    end
                    else
                    begin
                        state_next = hdlcft_pkg::SEQ_SHIFT;
                    end
                end
            end
            hdlcft_pkg::SEQ_PRE:
            begin
                if (step && cnt_reg == 7'd1)
                begin
                    state_next = hdlcft_pkg::SEQ_IDLE;
                end
            end
            hdlcft_pkg::SEQ_SHIFT:
            begin
                if (step && shift_done && !flag_pend_reg)
                begin
                    state_next = hdlcft_pkg::SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = hdlcft_pkg::SEQ_IDLE;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        sh_next         = sh_reg;
        cnt_next        = cnt_reg;
        ones_next       = ones_reg;
        stuff_pend_next = stuff_pend_reg;
        stuff_en_next   = stuff_en_reg;
        is_data_next    = is_data_reg;
        flag_pend_next  = flag_pend_reg;
        case (state_reg)
            hdlcft_pkg::SEQ_IDLE:
            begin
                if (in_fire)
                begin
                    stuff_pend_next = 1'b0;
                    case (op)
                        hdlcft_pkg::OP_START:
                        begin
                            cnt_next  = pre_cnt;
                            ones_next = '0;
                        end
                        hdlcft_pkg::OP_FLAG:
                        begin
                            sh_next        = {8'h00, hdlcft_pkg::FLAG_BITS};
                            cnt_next       = 7'd8;
                            ones_next      = '0;
                            stuff_en_next  = 1'b0;
                            is_data_next   = 1'b0;
                            flag_pend_next = 1'b0;
                        end
                        hdlcft_pkg::OP_DATA:
                        begin
                            sh_next        = {8'h00, data_byte};
                            cnt_next       = 7'd8;
                            stuff_en_next  = 1'b1;
                            is_data_next   = 1'b1;
                            flag_pend_next = 1'b0;
                        end
                        default:
                        begin
                            // frame check sequence, then closing flag
                            sh_next        = ~crc;
                            cnt_next       = 7'd16;
                            stuff_en_next  = 1'b1;
                            is_data_next   = 1'b0;
                            flag_pend_next = 1'b1;
                        end
                    endcase
                end
            end
            hdlcft_pkg::SEQ_PRE:
            begin
                if (step)
                begin
                    cnt_next = cnt_reg - 7'd1;
                end
            end
            hdlcft_pkg::SEQ_SHIFT:
            begin
                if (step)
                begin
                    if (stuff_pend_reg)
                    begin
                        stuff_pend_next = 1'b0;
                    end
                    else
                    begin
                        sh_next  = sh_reg >> 1;
                        cnt_next = cnt_reg - 7'd1;
                        if (stuff_en_reg)
                        begin
                            if (!sh_reg[0] || stuff_now)
                            begin
                                ones_next = '0;
                            end
                            else
                            begin
                                ones_next = ones_reg + 3'd1;
                            end
                            stuff_pend_next = stuff_now;
                        end
                    end
                    if (shift_done && flag_pend_reg)
                    begin
                        sh_next        = {8'h00, hdlcft_pkg::FLAG_BITS};
                        cnt_next       = 7'd8;
                        ones_next      = '0;
                        stuff_en_next  = 1'b0;
                        flag_pend_next = 1'b0;
                    end
                end
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        emit.valid   = step;
        emit.lbit    = (state_reg == hdlcft_pkg::SEQ_PRE) ? 1'b0 : bit_cur;
        emit.last    = (state_reg == hdlcft_pkg::SEQ_PRE) ? (cnt_reg == 7'd1)
                                                          : (shift_done && !flag_pend_reg);
        emit.lvl_rst = in_fire && (op == hdlcft_pkg::OP_START);

        crc_ctl.init  = in_fire && (op == hdlcft_pkg::OP_START);
        crc_ctl.shift = step && (state_reg == hdlcft_pkg::SEQ_SHIFT)
                        && !stuff_pend_reg && is_data_reg;
        crc_ctl.din   = sh_reg[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= hdlcft_pkg::SEQ_IDLE;
            ones_reg       <= '0;
            cnt_reg        <= '0;
            stuff_pend_reg <= 1'b0;
            stuff_en_reg   <= 1'b0;
            is_data_reg    <= 1'b0;
            flag_pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ones_reg       <= ones_next;
            cnt_reg        <= cnt_next;
            stuff_pend_reg <= stuff_pend_next;
            stuff_en_reg   <= stuff_en_next;
            is_data_reg    <= is_data_next;
            flag_pend_reg  <= flag_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg <= sh_next;
    end

    a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        emit.valid |-> adv)
        else $error("bit emitted into a busy output slot");

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == hdlcft_pkg::SEQ_IDLE |-> !stuff_pend_reg && !flag_pend_reg)
        else $error("idle with a stuff bit or closing flag still owed");

    a_stuff_run: assert property (@(posedge clk) disable iff (!rst_n)
        stuff_pend_reg |-> ones_reg == '0)
        else $error("ones run not cleared at stuffed zero");

endmodule

@@ hw/rtl/hdlc_frame_bit_transmitter.sv @@
// hdlc_frame_bit_transmitter: top level, configuration registers, NRZI and output register.
// Depends on hdlcft_pkg, hdlcft_crc, hdlcft_seq.
//
// Each line bit leaves the sequencer into the output register when the output slot is free.
// Throughput: one line bit per cycle unless out_ready stalls; a new word is taken only in idle.
//   Line bits per word: start min(preamble_zeros,64), flag 8, data 8..10, end 24..28.
//   A start word with zero preamble emits no line bits.
// Reset: CRC 0xFFFF, line level 1, ones run 0, preamble_zeros 20, nrzi_enable 1, idle.
module hdlc_frame_bit_transmitter (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration write port
    input  logic                                  cfg_we,
    input  logic [hdlcft_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hdlcft_pkg::CFG_DATA_W-1:0]     cfg_data,
    // input words
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [1:0]                            opcode,
    input  logic [7:0]                            data_byte,
    // output words, one per line bit
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  line_bit,
    output logic                                  last
);

    logic [hdlcft_pkg::PRE_W-1:0] preamble_reg;
    logic                         nrzi_reg;
    logic                         level_reg, level_next;
    logic                         out_valid_reg, out_valid_next;
    logic                         line_bit_reg, line_bit_next;
    logic                         last_reg, last_next;

    logic                         adv;
    hdlcft_pkg::crc_ctl_t         crc_ctl;
    hdlcft_pkg::emit_t            emit;
    logic [hdlcft_pkg::CRC_W-1:0] crc;

    // output slot is free when empty or being drained this cycle
    assign adv = !out_valid_reg || out_ready;

    hdlcft_crc u_crc (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (crc_ctl),
        .crc   (crc)
    );

    hdlcft_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .data_byte (data_byte),
        .preamble  (preamble_reg),
        .crc       (crc),
        .adv       (adv),
        .crc_ctl   (crc_ctl),
        .emit      (emit)
    );

    // configuration; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            preamble_reg <= hdlcft_pkg::PREAMBLE_RST;
            nrzi_reg     <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                hdlcft_pkg::REG_PREAMBLE: preamble_reg <= cfg_data;
                hdlcft_pkg::REG_NRZI:     nrzi_reg     <= cfg_data[0];
                default:                  ;
            endcase
        end
    end

    // NRZI: level flips on every zero, tracked even with coding off
    always_comb
    begin
        level_next     = level_reg;
        out_valid_next = out_valid_reg;
        line_bit_next  = line_bit_reg;
        last_next      = last_reg;
        if (emit.lvl_rst)
        begin
            level_next = 1'b1;
        end
        if (emit.valid)
        begin
            level_next     = level_reg ^ ~emit.lbit;
            out_valid_next = 1'b1;
            line_bit_next  = nrzi_reg ? (level_reg ^ ~emit.lbit) : emit.lbit;
            last_next      = emit.last;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            level_reg     <= level_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        line_bit_reg <= line_bit_next;
        last_reg     <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign line_bit  = line_bit_reg;
    assign last      = last_reg;

    a_start_level: assert property (@(posedge clk) disable iff (!rst_n)
        emit.lvl_rst |=> level_reg)
        else $error("line level not reset by start");

endmodule

@@ dv/tb.sv @@
// tb: self-checking testbench for hdlc_frame_bit_transmitter (HDLC framing, stuffing,
// CRC-16 FCS, NRZI). Depends on hdlcft_pkg and the hdlc_frame_bit_transmitter RTL only.
module tb;

    import hdlcft_pkg::*;

    // indexes past the two real registers; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int          N_DIR       = 33;
    localparam int          RAND_WORDS  = 42;   // per idling phase, four phases
    localparam int          SETTLE_CYC  = 4;    // covers a start word with no preamble bits

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [1:0]            opcode;
    logic [7:0]            data_byte;
    logic                  out_valid;
    logic                  out_ready;
    logic                  line_bit;
    logic                  last;

    hdlc_frame_bit_transmitter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .data_byte (data_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .line_bit  (line_bit),
        .last      (last)
    );

    // one expected line bit
    typedef struct packed {
        logic lb;
        logic lst;
    } line_exp_t;

    // directed stimulus row: either a register write or a word.
    // tn < 0: line bits come from the frame model; otherwise tn raw line bits
    // are typed in tbits, bit i being the i-th bit on the line.
    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] val;
        op_t                   op;
        logic [7:0]            dbyte;
        int                    tn;
        logic [63:0]           tbits;
    } row_t;

    row_t dir_rows [N_DIR] = '{
        // reset settings: 20 preamble zeros, NRZI on; level starts at 1 and
        // toggles on every zero, so the preamble alternates 0,1,0,1...
        '{1'b0, REG_PREAMBLE, 7'd0,   OP_START, 8'h00, 20, 64'h00000000000AAAAA},
        '{1'b0, REG_PREAMBLE, 7'd0,   OP_FLAG,  8'h00, 8,  64'h0000000000000080},
        '{1'b0, REG_PREAMBLE, 7'd0,   OP_DATA,  8'h00, -1, 64'h0},
        '{1'b0, REG_PREAMBLE, 7'd0,   OP_DATA,  8'hFF, -1, 64'h0},
        '{1'b0, REG_PREAMBLE, 7'd0,   OP_DATA,  8'h7E, -1, 64'h0},
        '{1'b0, REG_PREAMBLE, 7'd0,   OP_DATA,  8'hA5, -1, 64'h0},
        '{1'b0, REG_PREAMBLE, 7'd0,   OP_END,   8'hFF, -1, 64'h0},
        // empty preamble, raw bits; spare indexes must not alias real registers
        '{1'b1, REG_PREAMBLE, 7'd0,   OP_START, 8'h00, -1, 64'h0},
        '{1'b1, REG_NRZI,     7'd0,   OP_START, 8'h00, -1, 64'h0},
        '{1'b1, REG_SPARE_A,  7'd127, OP_START, 8'h00, -1, 64'h0},
        '{1'b1, REG_SPARE_B,  7'd1,   OP_START, 8'h00, -1, 64'h0},
        '{1'b0, REG_PREAMBLE, 7'd0,   OP_START, 8'hFF, 0,  64'h0},
        '{1'b0, REG_PREAMBLE, 7'd0,   OP_FLAG,  8'h00, 8,  64'h000000000000007E},
        '{1'b0, REG_PREAMBLE, 7'd0,   OP_DATA,  8'h00, 8,  64'h0},
        // all ones: stuffed zero after five, and the run carries into the next byte
        '{1'b0, REG_PREAMBLE, 7'd0,   OP_DATA,  8'hFF, 9,  64'h00000000000001DF},
        '{1'b0, REG_PREAMBLE, 7'd0,   OP_DATA,  8'hFF, 10, 64'h00000000000002FB},
        '{1'b0, REG_PREAMBLE, 7'd0,   OP_DATA,  8'h01, -1, 64'h0},
        '{1'b0, REG_PREAMBLE, 7'd0,   OP_END,   8'h00, -1, 64'h0},
        // second end with no start: CRC keeps running
        '{1'b0, REG_PREAMBLE, 7'd0,   OP_END,   8'h00, -1, 64'h0},
        // NRZI back on mid-stream; level was tracked all along
        '{1'b1, REG_NRZI,     7'd1,   OP_START, 8'h00, -1, 64'h0},
        '{1'b0, REG_PREAMBLE, 7'd0,   OP_FLAG,  8'h00, -1, 64'h0},
        '{1'b0, REG_PREAMBLE, 7'd0,   OP_DATA,  8'h3C, -1, 64'h0},
        // preamble above range saturates at 64
        '{1'b1, REG_PREAMBLE, 7'd127, OP_START, 8'h00, -1, 64'h0},
        '{1'b0, REG_PREAMBLE, 7'd0,   OP_START, 8'h00, 64, 64'hAAAAAAAAAAAAAAAA},
        '{1'b0, REG_PREAMBLE, 7'd0,   OP_FLAG,  8'h00, 8,  64'h0000000000000080},
        '{1'b1, REG_PREAMBLE, 7'd64,  OP_START, 8'h00, -1, 64'h0},
        '{1'b1, REG_NRZI,     7'd0,   OP_START, 8'h00, -1, 64'h0},
        '{1'b0, REG_PREAMBLE, 7'd0,   OP_START, 8'h00, 64, 64'h0},
        '{1'b0, REG_PREAMBLE, 7'd0,   OP_DATA,  8'h55, -1, 64'h0},
        '{1'b0, REG_PREAMBLE, 7'd0,   OP_END,   8'h00, -1, 64'h0},
        '{1'b1, REG_PREAMBLE, 7'd1,   OP_START, 8'h00, -1, 64'h0},
        '{1'b0, REG_PREAMBLE, 7'd0,   OP_START, 8'h00, 1,  64'h0},
        // FCS of an empty frame
        '{1'b0, REG_PREAMBLE, 7'd0,   OP_END,   8'h00, -1, 64'h0}
    };

    // frame model: configuration copy and running frame state
    logic [PRE_W-1:0] pre_cfg;
    logic             nrzi_cfg;
    logic [CRC_W-1:0] fcs_acc;
    logic [RUN_W-1:0] ones_cnt;
    logic             level_now;
    logic             word_lb [64];   // line bits of the word being modeled
    int               word_n;

    line_exp_t        line_bits_q [$];   // line bits still owed by the block

    int               gap_pct;     // sender idle chance per cycle
    int               stall_pct;   // receiver stall chance per cycle
    int               words_sent;
    int               mismatches;
    int unsigned      cycle_count = 0;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // ---------------------------------------------------------------
    // Frame model
    // ---------------------------------------------------------------

    // every zero on the line flips the NRZI level, raw mode included
    task automatic put_bit(input logic b);
        if (!b)
            level_now = ~level_now;
        word_lb[word_n] = nrzi_cfg ? level_now : b;
        word_n++;
    endtask

    task automatic put_stuffed(input logic [7:0] v);
        for (int i = 0; i < 8; i++)
        begin
            put_bit(v[i]);
            if (v[i])
            begin
                ones_cnt++;
                if (ones_cnt == STUFF_RUN)
                begin
                    put_bit(1'b0);
                    ones_cnt = '0;
                end
            end
            else
                ones_cnt = '0;
        end
    endtask

    // flag goes out MSB first, never stuffed
    task automatic put_flag();
        for (int i = 7; i >= 0; i--)
            put_bit(FLAG_BITS[i]);
        ones_cnt = '0;
    endtask

    task automatic model_word(input op_t op, input logic [7:0] v);
        logic             mix;
        logic [CRC_W-1:0] fcs;
        logic [PRE_W-1:0] cnt;
        word_n = 0;
        case (op)
            OP_START:
            begin
                fcs_acc   = CRC_INIT;
                ones_cnt  = '0;
                level_now = 1'b1;
                cnt = (pre_cfg > PREAMBLE_MAX) ? PREAMBLE_MAX : pre_cfg;
                repeat (cnt) put_bit(1'b0);
            end
            OP_FLAG:
                put_flag();
            OP_DATA:
            begin
                // reflected CRC, LSB of the byte first
                for (int i = 0; i < 8; i++)
                begin
                    mix     = v[i] ^ fcs_acc[0];
                    fcs_acc = fcs_acc >> 1;
                    if (mix)
                        fcs_acc = fcs_acc ^ CRC_POLY;
                end
                put_stuffed(v);
            end
            default:
            begin
                fcs = ~fcs_acc;
                put_stuffed(fcs[7:0]);
                put_stuffed(fcs[15:8]);
                put_flag();
            end
        endcase
    endtask

    // ---------------------------------------------------------------
    // Driving: inputs change on the falling edge
    // ---------------------------------------------------------------

    // Offers one word, holds it until taken, then books its line bits.
    // Valid is left high after acceptance; the next call or settle() decides
    // at the next falling edge whether it drops.
    task automatic send_word(input op_t op, input logic [7:0] v, input int tn,
                             input logic [63:0] tbits);
        line_exp_t e;
        int        n;
        @(negedge clk);
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid  = 1'b1;
        opcode    = op;
        data_byte = v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        words_sent++;
        model_word(op, v);
        n = (tn < 0) ? word_n : tn;
        for (int i = 0; i < n; i++)
        begin
            e.lb  = (tn < 0) ? word_lb[i] : tbits[i];
            e.lst = (i == n - 1);
            line_bits_q.insert(line_bits_q.size(), e);
        end
    endtask

    // block idle: nothing owed, then a SETTLE_CYC wait for a word with no bits
    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (line_bits_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == REG_PREAMBLE)
            pre_cfg = val;
        else if (idx == REG_NRZI)
            nrzi_cfg = val[0];
    endtask

    // short preambles mostly, now and then the saturating range
    task automatic reconfigure();
        settle();
        if ($urandom_range(7) == 0)
            write_reg(REG_PREAMBLE, 7'($urandom_range(64, 127)));
        else
            write_reg(REG_PREAMBLE, 7'($urandom_range(0, 12)));
        write_reg(REG_NRZI, 7'($urandom));
        if ($urandom_range(3) == 0)
            write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, 7'($urandom));
    endtask

    // mostly well-formed frames with random content, some loose noise
    task automatic random_frame();
        int nbytes;
        if ($urandom_range(9) < 8)
        begin
            send_word(OP_START, 8'($urandom), -1, '0);
            repeat ($urandom_range(1, 3)) send_word(OP_FLAG, 8'($urandom), -1, '0);
            nbytes = ($urandom_range(5) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 8);
            repeat (nbytes) send_word(OP_DATA, 8'($urandom), -1, '0);
            send_word(OP_END, 8'($urandom), -1, '0);
            if ($urandom_range(1))
                send_word(OP_FLAG, 8'($urandom), -1, '0);
        end
        else
        begin
            repeat ($urandom_range(1, 6))
                send_word(op_t'($urandom_range(3)), 8'($urandom), -1, '0);
        end
    endtask

    // ---------------------------------------------------------------
    // Receiver: stalls at random, decided on the falling edge
    // ---------------------------------------------------------------
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready = ($urandom_range(99) >= stall_pct);
        end
    end

    // ---------------------------------------------------------------
    // Checker: each line bit taken is matched against the oldest owed one
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin : line_check
        line_exp_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (line_bits_q.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected line bit: line_bit=%0b last=%0b", line_bit, last);
                mismatches++;
            end
            else
            begin
                want = line_bits_q.pop_front();
                if (line_bit !== want.lb || last !== want.lst)
                begin
                    if (mismatches < 10)
                        $display("mismatch: expected line_bit=%0b last=%0b,",
                                 want.lb, want.lst,
                                 " got line_bit=%0b last=%0b", line_bit, last);
                    mismatches++;
                end
            end
        end
    end

    // hang guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin
        int target;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = REG_PREAMBLE;
        cfg_data   = '0;
        in_valid   = 1'b0;
        opcode     = OP_START;
        data_byte  = '0;
        gap_pct    = 0;
        stall_pct  = 0;
        words_sent = 0;
        mismatches = 0;

        // model state after reset
        pre_cfg   = PREAMBLE_RST;
        nrzi_cfg  = 1'b1;
        fcs_acc   = CRC_INIT;
        ones_cnt  = '0;
        level_now = 1'b1;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table, no idling
        for (int i = 0; i < N_DIR; i++)
        begin
            if (dir_rows[i].is_cfg)
            begin
                settle();
                write_reg(dir_rows[i].idx, dir_rows[i].val);
            end
            else
                send_word(dir_rows[i].op, dir_rows[i].dbyte, dir_rows[i].tn,
                          dir_rows[i].tbits);
        end

        // random frames under four idling mixes; each phase opens from a
        // fully drained block, so the sender waits out every owed bit there
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:
                begin
                    gap_pct   = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    gap_pct   = 75;
                    stall_pct = 0;
                end
                2:
                begin
                    gap_pct   = 0;
                    stall_pct = 75;
                end
                default:
                begin
                    gap_pct   = 35;
                    stall_pct = 35;
                end
            endcase
            reconfigure();
            target = words_sent + RAND_WORDS;
            while (words_sent < target)
            begin
                random_frame();
                if ($urandom_range(2) == 0)
                    reconfigure();
            end
        end

        settle();
        repeat (20) @(negedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ hdlc_frame_bit_transmitter.f @@
hw/rtl/hdlcft_pkg.sv
hw/rtl/hdlcft_crc.sv
hw/rtl/hdlcft_seq.sv
hw/rtl/hdlc_frame_bit_transmitter.sv
dv/tb.sv
